@@ hw/rtl/pwm_duty_capture_meter_macros.svh @@
// Assertion macros for the PWM duty capture meter.
`ifndef PWM_DUTY_CAPTURE_METER_MACROS_SVH
`define PWM_DUTY_CAPTURE_METER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDCM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pwm duty meter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PDCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pwm duty meter: next-cycle check failed");

`endif

@@ hw/rtl/pdcm_pkg.sv @@
// Shared types and constants of the PWM duty capture meter.
package pdcm_pkg;

    localparam int TICKS_W   = 16;
    localparam int DUTY_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 16'h7FFF;
    localparam logic [DUTY_W-1:0] DUTY_ZERO = 16'h0000;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_VALUE  = 1'd1;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_start;
        logic div_step;
        logic div_write;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_needed;
    } t_dp_status;

endpackage

@@ hw/rtl/pdcm_in_if.sv @@
// Input channel carrying one capture event item.
interface pdcm_in_if
    import pdcm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               overflow_event;
    logic               capture_event;
    logic [TICKS_W-1:0] capture_ticks;
    logic               pin_level;

    modport source (
        output valid, overflow_event, capture_event, capture_ticks, pin_level,
        input  ready
    );

    modport sink (
        input  valid, overflow_event, capture_event, capture_ticks, pin_level,
        output ready
    );
endinterface

@@ hw/rtl/pdcm_out_if.sv @@
// Output channel carrying one duty result item.
interface pdcm_out_if
    import pdcm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_fraction;
    logic              next_edge_falling;

    modport source (
        output valid, duty_fraction, next_edge_falling,
        input  ready
    );

    modport sink (
        input  valid, duty_fraction, next_edge_falling,
        output ready
    );
endinterface

@@ hw/rtl/pwm_duty_capture_meter.sv @@
// Top level of the PWM duty capture meter.
//
//   Channel    Direction  Handshake    Payload
//   i_item     in         valid/ready  overflow_event, capture_event, capture_ticks, pin_level
//   o_result   out        valid/ready  duty_fraction, next_edge_falling
//   i_cfg_*    in         write enable override_enable (0), override_value (1)
//
// An item that needs a division passes through ST_EVAL, ST_DIV, ST_WB and ST_EMIT from
// acceptance to the next possible acceptance; any other item passes through ST_EVAL and ST_EMIT.
// The bit-serial restoring divider in ST_DIV produces one quotient bit per cycle.
// Reset is synchronous and active low and resets all state but the divider and result registers.
// The result register holds a finished item while the sink stalls; if the next result
// is ready before it is taken, the controller waits and accepts no new item meanwhile.
`include "pwm_duty_capture_meter_macros.svh"

module pwm_duty_capture_meter
    import pdcm_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pdcm_in_if.sink              i_item,
    pdcm_out_if.source           o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic              r_ovr_en;
    logic [DUTY_W-1:0] r_ovr_val;
    t_dp_cmd           w_cmd;
    t_dp_status        w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovr_en  <= 1'b0;
            r_ovr_val <= DUTY_FULL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OVERRIDE_ENABLE: r_ovr_en  <= i_cfg_data[0];
                CFG_OVERRIDE_VALUE:  r_ovr_val <= i_cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pdcm_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    pdcm_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_overflow_event    (i_item.overflow_event),
        .i_capture_event     (i_item.capture_event),
        .i_capture_ticks     (i_item.capture_ticks),
        .i_pin_level         (i_item.pin_level),
        .i_ovr_en            (r_ovr_en),
        .i_ovr_val           (r_ovr_val),
        .o_duty_fraction     (o_result.duty_fraction),
        .o_next_edge_falling (o_result.next_edge_falling)
    );

    `PDCM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_item.valid && i_item.ready, !i_item.ready)
    `PDCM_ASSERT_NEXT(a_result_after_emit, i_clk, i_rst_n,
        w_cmd.emit, o_result.valid)
    `PDCM_ASSERT_NEXT(a_override_applied, i_clk, i_rst_n,
        w_cmd.emit && r_ovr_en, o_result.duty_fraction == $past(r_ovr_val))
    `PDCM_ASSERT_SAME(a_single_command, i_clk, i_rst_n,
        1'b1, $onehot0(w_cmd))

endmodule

@@ hw/rtl/pdcm_datapath.sv @@
// Datapath: capture state, bit-serial restoring divider and result register.
module pdcm_datapath
    import pdcm_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic               i_overflow_event,
    input  logic               i_capture_event,
    input  logic [TICKS_W-1:0] i_capture_ticks,
    input  logic               i_pin_level,
    input  logic               i_ovr_en,
    input  logic [DUTY_W-1:0]  i_ovr_val,
    output logic [DUTY_W-1:0]  o_duty_fraction,
    output logic               o_next_edge_falling
);

    localparam int NUM_W = 2 * COUNT_BITS;

    logic                  r_expect_fall;
    logic [COUNT_BITS-1:0] r_high;
    logic [COUNT_BITS-1:0] r_low;
    logic                  r_lvl_fall;
    logic                  r_lvl_rise;
    logic [DUTY_W-1:0]     r_duty;
    logic                  r_cap;

    logic [NUM_W-1:0]      r_num;
    logic [COUNT_BITS-1:0] r_div;
    logic [COUNT_BITS:0]   r_rem;
    logic [DUTY_W:0]       r_quo;
    logic                  r_big;

    logic [DUTY_W-1:0]     r_out_duty;
    logic                  r_out_fall;

    logic [COUNT_BITS-1:0] w_ticks;
    logic [COUNT_BITS-1:0] w_sum;
    logic [COUNT_BITS:0]   w_shift;
    logic                  w_ge;
    logic [DUTY_W-1:0]     w_duty_out;

    assign w_ticks    = COUNT_BITS'(i_capture_ticks);
    assign w_sum      = r_low + r_high;
    assign w_shift    = {r_rem[COUNT_BITS-1:0], r_num[NUM_W-1]};
    assign w_ge       = (w_shift >= {1'b0, r_div});
    assign w_duty_out = i_ovr_en ? i_ovr_val : r_duty;

    assign o_status.div_needed = r_cap && r_lvl_rise && !r_lvl_fall && (w_sum != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_fall <= 1'b0;
            r_high        <= '0;
            r_low         <= '0;
            r_lvl_fall    <= 1'b0;
            r_lvl_rise    <= 1'b0;
            r_duty        <= DUTY_ZERO;
            r_cap         <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cap <= i_capture_event;
                if (i_overflow_event) begin
                    r_duty <= i_pin_level ? DUTY_ZERO : DUTY_FULL;
                end
                if (i_capture_event) begin
                    if (r_expect_fall) begin
                        r_expect_fall <= 1'b0;
                        r_high        <= w_ticks;
                        r_lvl_fall    <= i_pin_level;
                    end else begin
                        r_expect_fall <= 1'b1;
                        r_low         <= w_ticks;
                        r_lvl_rise    <= i_pin_level;
                    end
                end
            end
            if (i_cmd.eval && r_cap) begin
                if (!r_lvl_rise) begin
                    r_duty <= DUTY_FULL;
                end else if (r_lvl_fall) begin
                    r_duty <= DUTY_ZERO;
                end else begin
                    r_duty <= DUTY_FULL;
                end
            end
            if (i_cmd.div_write) begin
                r_duty <= (r_big || r_quo[DUTY_W]) ? DUTY_FULL
                                                   : {1'b0, r_quo[DUTY_W-1:1]};
            end
            if (i_cmd.emit) begin
                r_duty <= w_duty_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_num <= {r_low, {COUNT_BITS{1'b0}}} - {{COUNT_BITS{1'b0}}, r_low};
            r_div <= w_sum;
            r_rem <= '0;
            r_quo <= '0;
            r_big <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= w_ge ? (w_shift - {1'b0, r_div}) : w_shift;
            r_quo <= {r_quo[DUTY_W-1:0], w_ge};
            r_big <= r_big | r_quo[DUTY_W];
        end
        if (i_cmd.emit) begin
            r_out_duty <= w_duty_out;
            r_out_fall <= r_expect_fall;
        end
    end

    assign o_duty_fraction     = r_out_duty;
    assign o_next_edge_falling = r_out_fall;

endmodule

@@ hw/rtl/pdcm_ctrl.sv @@
// Controller: sequences load, evaluation, division and result handoff.
module pdcm_ctrl
    import pdcm_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int STEPS  = 2 * COUNT_BITS;
    localparam int STEP_W = $clog2(STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_WB,
        ST_EMIT
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic              w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.eval      = (r_state == ST_EVAL) && !i_status.div_needed;
        o_cmd.div_start = (r_state == ST_EVAL) && i_status.div_needed;
        o_cmd.div_step  = (r_state == ST_DIV);
        o_cmd.div_write = (r_state == ST_WB);
        o_cmd.emit      = (r_state == ST_EMIT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    r_step  <= '0;
                    r_state <= i_status.div_needed ? ST_DIV : ST_EMIT;
                end
                ST_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(STEPS - 1)) begin
                        r_state <= ST_WB;
                    end
                end
                ST_WB: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
